FILE: rtl/mpls_pkg.sv
// Shared types and constants of the memory-proportional layer split.
`timescale 1ns / 1ps

package mpls_pkg;

  localparam int MemW    = 24;
  localparam int SumW    = 30;
  localparam int LayerW  = 12;
  localparam int RankW   = 6;
  localparam int ProdW   = LayerW + MemW;
  localparam int NumW    = ProdW + 2;
  localparam int DivW    = SumW + 1;
  localparam int QuotW   = LayerW;
  localparam int DivCntW = $clog2(QuotW);

  typedef logic [LayerW-1:0] layer_t;

  typedef struct packed {
    logic [MemW-1:0] memory_units;
    logic            last_node;
  } in_item_t;

  typedef struct packed {
    logic [RankW-1:0]  rank;
    logic [LayerW-1:0] range_lo;
    logic [LayerW-1:0] range_hi;
    logic              last_assignment;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic start;
    logic clear;
    logic rd;
    logic mul;
    logic div_init;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic layers_zero;
    logic is_final;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/mpls_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
`timescale 1ns / 1ps

interface mpls_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/memory_proportional_layer_split_core.sv
// Top level of the memory-proportional layer split.
// Each input item taken while idle loads one node's memory figure while the
// node store has room; the item flagged last_node starts the split, during
// which no input is taken. Every node but the final one passes through store
// read, multiply, divider load, 12 steps of the restoring divider that forms
// the rounded share, and result load; the final node passes through store read
// and result load only. The 12-step divider sets the split rate. A held result
// register stalls the split only while the output side is not ready. With a
// layer count of zero the flagged item gives no result and the block stays idle.
`timescale 1ns / 1ps

module memory_proportional_layer_split_core
  import mpls_pkg::*;
#(
  parameter int MaxNodes = 64
) (
  input logic         clk_i,
  input logic         rst_ni,
  mpls_chan_if.sink   cfg_chan,
  mpls_chan_if.sink   in_chan,
  mpls_chan_if.source out_chan
);

  layer_t     layer_total_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_total_q <= '0;
    end else if (cfg_chan.valid) begin
      layer_total_q <= cfg_chan.payload;
    end
  end

  mpls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_last_i  (in_chan.payload.last_node),
    .in_ready_o (in_chan.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpls_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .layer_total_i (layer_total_q),
    .in_item_i     (in_chan.payload),
    .out_valid_o   (out_chan.valid),
    .out_item_o    (out_chan.payload),
    .out_ready_i   (out_chan.ready)
  );

  // the final range always closes at the layer count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid && out_chan.payload.last_assignment |->
      out_chan.payload.range_hi == layer_total_q)
    else $error("final range does not end at layer count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |-> out_chan.payload.range_lo <= out_chan.payload.range_hi)
    else $error("range start beyond range end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_chan.valid |-> out_chan.payload.range_hi <= layer_total_q)
    else $error("range end beyond layer count");

  // no node is loaded while a split is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step || cmd.mul || cmd.rd |-> !in_chan.ready)
    else $error("input taken during split");

endmodule

FILE: rtl/mpls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mpls_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mpls_ctrl.sv
// Sequencer for loading nodes and stepping through the per-node split.
`timescale 1ns / 1ps

module mpls_ctrl
  import mpls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMul,
    StDivInit,
    StDiv,
    StEmit
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            if (status_i.layers_zero) begin
              cmd_o.clear = 1'b1;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = StRead;
            end
          end
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        // the final node takes the remainder, no division
        state_d = status_i.is_final ? StEmit : StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StDivInit;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.is_final) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end else begin
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/mpls_dp.sv
// Datapath: node store, memory sum, share multiply and divide, result register.
`timescale 1ns / 1ps

module mpls_dp
  import mpls_pkg::*;
#(
  parameter int MaxNodes = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  layer_t     layer_total_i,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o,
  input  logic       out_ready_i
);

  localparam int CntW  = $clog2(MaxNodes + 1);
  localparam int AddrW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;

  logic [SumW-1:0]    sum_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    idx_q;
  logic [LayerW-1:0]  assigned_q;
  logic [ProdW-1:0]   prod_q;
  logic [DivW-1:0]    rem_q;
  logic [QuotW-1:0]   num_lo_q;
  logic [QuotW-1:0]   quot_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  logic               room;
  logic [MemW-1:0]    rd_data;
  logic [SumW-1:0]    total;
  logic [DivW-1:0]    divisor;
  logic [NumW-1:0]    num;
  logic [DivW:0]      trial;
  logic               trial_ge;
  logic [LayerW-1:0]  remaining;
  logic [LayerW-1:0]  q_min;
  logic [LayerW-1:0]  share;
  logic               is_final;

  assign room = (count_q != CntW'(MaxNodes));

  mpls_ram #(
    .Width (MemW),
    .Depth (MaxNodes)
  ) u_node_mem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && room),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (in_item_i.memory_units),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rd_data)
  );

  // a zero total counts as one
  assign total    = (sum_q == '0) ? SumW'(1) : sum_q;
  assign divisor  = {total, 1'b0};
  assign num      = NumW'({prod_q, 1'b0}) + NumW'(total);
  assign trial    = {rem_q, num_lo_q[QuotW-1]};
  assign trial_ge = (trial >= (DivW + 1)'(divisor));

  assign is_final  = ((idx_q + CntW'(1)) == count_q);
  assign remaining = layer_total_i - assigned_q;
  assign q_min     = (quot_q == '0) ? LayerW'(1) : quot_q;

  always_comb begin
    if (is_final) begin
      share = remaining;
    end else if (q_min > remaining) begin
      share = remaining;
    end else begin
      share = q_min;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      assigned_q  <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        sum_q      <= '0;
        count_q    <= '0;
        assigned_q <= '0;
      end else begin
        if (cmd_i.load && room) begin
          sum_q   <= sum_q + SumW'(in_item_i.memory_units);
          count_q <= count_q + CntW'(1);
        end
        if (cmd_i.start) begin
          assigned_q <= '0;
        end else if (cmd_i.emit) begin
          assigned_q <= assigned_q + share;
        end
      end
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= ProdW'(layer_total_i) * ProdW'(rd_data);
    end
    if (cmd_i.div_init) begin
      rem_q    <= DivW'(num[NumW-1:QuotW]);
      num_lo_q <= num[QuotW-1:0];
      quot_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q    <= trial_ge ? DivW'(trial - (DivW + 1)'(divisor)) : DivW'(trial);
      num_lo_q <= {num_lo_q[QuotW-2:0], 1'b0};
      quot_q   <= {quot_q[QuotW-2:0], trial_ge};
    end
    if (cmd_i.emit) begin
      out_item_q.rank            <= RankW'(idx_q);
      out_item_q.range_lo        <= assigned_q;
      out_item_q.range_hi        <= assigned_q + share;
      out_item_q.last_assignment <= is_final;
    end
  end

  assign status_o.layers_zero = (layer_total_i == '0);
  assign status_o.is_final    = is_final;
  assign status_o.div_done    = (div_cnt_q == DivCntW'(QuotW - 1));
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: test/tb_memory_proportional_layer_split_core.sv
// Testbench for the memory-proportional layer split core, self-checking against a predictor.
`timescale 1ns / 1ps

module tb_memory_proportional_layer_split_core
  import mpls_pkg::*;
;

  localparam int NodeCap     = 64;
  localparam int DrainCycles = 40;
  localparam int StallCycles = 600;

  typedef out_item_t range_q_t[$];

  typedef enum logic {ROW_CFG, ROW_NODE} row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic [MemW-1:0] value;
    logic            last;
    logic            typed;
    int              n_res;
    out_item_t       res;
  } row_t;

  logic clk_i;
  logic rst_ni;

  mpls_chan_if #(.payload_t(layer_t))    cfg_chan ();
  mpls_chan_if #(.payload_t(in_item_t))  in_chan ();
  mpls_chan_if #(.payload_t(out_item_t)) out_chan ();

  memory_proportional_layer_split_core #(
    .MaxNodes(NodeCap)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_chan(cfg_chan),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Predicted state of the block
  logic [MemW-1:0] node_mem [NodeCap];
  logic [SumW-1:0] mem_sum = '0;
  int unsigned     node_cnt = 0;
  layer_t          layers = '0;

  out_item_t   pending_ranges[$];
  int unsigned snd_idle = 15;
  int unsigned rcv_idle = 15;
  int          stall_left = 0;
  int          fail_cnt = 0;

  // Single-node sets and empty results are typed in; the rest go through split_node.
  row_t dir_tab [26] = '{
    '{ROW_CFG,  24'd4095,   1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b1, 1'b1, 1, '{6'd0, 12'd0, 12'd4095, 1'b1}},
    '{ROW_NODE, 24'h000000, 1'b1, 1'b1, 1, '{6'd0, 12'd0, 12'd4095, 1'b1}},
    '{ROW_CFG,  24'd0,      1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h003039, 1'b0, 1'b1, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b1, 1'b1, 0, '0},
    '{ROW_CFG,  24'd1,      1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000001, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b1, 1'b0, 0, '0},
    '{ROW_CFG,  24'd10,     1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000000, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000000, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000000, 1'b1, 1'b0, 0, '0},
    '{ROW_CFG,  24'd4095,   1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'd100,    1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'd300,    1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'd600,    1'b1, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b1, 1'b0, 0, '0},
    '{ROW_CFG,  24'd3,      1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000001, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000001, 1'b1, 1'b0, 0, '0},
    '{ROW_CFG,  24'd4095,   1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'h000000, 1'b0, 1'b0, 0, '0},
    '{ROW_NODE, 24'hFFFFFF, 1'b1, 1'b0, 0, '0}
  };

  // Store one node; on the flagged item, work out every range of the set.
  function automatic range_q_t split_node(input in_item_t it);
    range_q_t          res;
    out_item_t         r;
    int unsigned       n;
    int unsigned       done;
    int unsigned       share;
    longint unsigned   tot;
    longint unsigned   num;
    if (node_cnt < NodeCap) begin
      node_mem[node_cnt] = it.memory_units;
      mem_sum = mem_sum + SumW'(it.memory_units);
      node_cnt++;
    end
    if (!it.last_node) return res;
    n = node_cnt;
    done = 0;
    if (layers != '0) begin
      for (int unsigned i = 0; i < n; i++) begin
        if (i + 1 == n) begin
          share = layers - done;
        end else begin
          // a zero total counts as one
          tot = mem_sum;
          if (tot == 0) tot = 1;
          num = longint'(layers);
          num = 2 * num * longint'(node_mem[i]) + tot;
          share = int'(num / (2 * tot));
          if (share < 1) share = 1;
          if (done + share > layers) share = layers - done;
        end
        r.rank            = RankW'(i);
        r.range_lo        = LayerW'(done);
        r.range_hi        = LayerW'(done + share);
        r.last_assignment = (i + 1 == n);
        res.insert(res.size(), r);
        done += share;
      end
    end
    node_cnt = 0;
    mem_sum = '0;
    return res;
  endfunction

  function automatic logic [MemW-1:0] pick_memory();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return MemW'($urandom_range(0, 15));
      3:       return {MemW{1'b1}} - MemW'($urandom_range(0, 15));
      default: return MemW'($urandom());
    endcase
  endfunction

  task automatic push_node(input in_item_t it, input logic typed = 1'b0,
                           input int n_typed = 0, input out_item_t typed_res = '0);
    range_q_t got;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    got = split_node(it);
    if (!typed) begin
      foreach (got[k]) pending_ranges.insert(pending_ranges.size(), got[k]);
    end else if (n_typed != 0) begin
      pending_ranges.insert(pending_ranges.size(), typed_res);
    end
  endtask

  task automatic write_layers(input layer_t l);
    cfg_chan.valid   <= 1'b1;
    cfg_chan.payload <= l;
    @(posedge clk_i);
    while (!cfg_chan.ready) @(posedge clk_i);
    layers = l;
    cfg_chan.valid <= 1'b0;
  endtask

  // Drop the input, wait for every range, then let the split wind down.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Output side: random back-pressure, long hold-off on request, compare each range.
  initial begin
    out_item_t want;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_chan.valid && out_chan.ready) begin
        if (pending_ranges.size() == 0) begin
          $error("unexpected range: rank %0d start %0d end %0d", out_chan.payload.rank,
                 out_chan.payload.range_lo, out_chan.payload.range_hi);
          fail_cnt++;
        end else begin
          want = pending_ranges.pop_front();
          check_field("rank", want.rank, out_chan.payload.rank);
          check_field("range_lo", want.range_lo, out_chan.payload.range_lo);
          check_field("range_hi", want.range_hi, out_chan.payload.range_hi);
          check_field("last_assignment", want.last_assignment,
                      out_chan.payload.last_assignment);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  initial begin
    layer_t      l;
    int unsigned sent;
    int unsigned n;
    in_chan.valid    = 1'b0;
    in_chan.payload  = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.payload = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_layers(dir_tab[i].value[LayerW-1:0]);
      end else begin
        push_node('{memory_units: dir_tab[i].value, last_node: dir_tab[i].last},
                  dir_tab[i].typed, dir_tab[i].n_res, dir_tab[i].res);
      end
    end

    for (int k = 0; k < 8; k++) begin
      settle();
      case (k % 4)
        0:       begin snd_idle = 0;  rcv_idle = 0;  end
        1:       begin snd_idle = 49; rcv_idle = 0;  end
        2:       begin snd_idle = 0;  rcv_idle = 49; end
        default: begin snd_idle = 15; rcv_idle = 15; end
      endcase
      case (k)
        0:       l = '1;
        1:       l = LayerW'($urandom_range(2, 20));
        2:       l = '0;
        3:       l = LayerW'($urandom_range(0, 4095));
        4:       l = LayerW'(1);
        5:       l = LayerW'($urandom_range(1, 300));
        6:       l = '1;
        default: l = LayerW'($urandom_range(21, 4095));
      endcase
      write_layers(l);
      if (k == 6) begin
        // Overfill the node set and hold the output off so the split backs up
        snd_idle = 0;
        rcv_idle = 0;
        stall_left = StallCycles;
        for (int j = 0; j < NodeCap + 3; j++) begin
          push_node('{memory_units: pick_memory(), last_node: (j == NodeCap + 2)});
        end
      end
      sent = 0;
      while (sent < 2) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
        for (int j = 0; j < n; j++) begin
          push_node('{memory_units: pick_memory(), last_node: (j == n - 1)});
        end
        sent += n;
      end
    end
    settle();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/mpls_pkg.sv
rtl/mpls_chan_if.sv
rtl/mpls_ram.sv
rtl/mpls_ctrl.sv
rtl/mpls_dp.sv
rtl/memory_proportional_layer_split_core.sv
test/tb_memory_proportional_layer_split_core.sv
